>>> hw/rtl/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg
// shared widths, command codes, register map and the cell control bundle
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int CMD_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 7;
    localparam int IDX_W   = 6;
    localparam int WIDE_W  = POS_W + 2;   // holds any cell index plus one, up to 511
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam int DEPTH_DEF = 64;

    localparam logic [POS_W-1:0] CAP_RST  = 7'd64;
    localparam logic [POS_W-1:0] MOVE_RST = 7'd16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MAXL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MAXR   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd7;

    // register select, taken from paddr bit 2
    localparam logic REG_CAP  = 1'b0;
    localparam logic REG_MOVE = 1'b1;

    // broadcast from the controller to every cell of the row
    typedef struct packed {
        logic              put_en;
        logic              del_en;
        logic [POS_W-1:0]  cursor;
        logic [POS_W-1:0]  count;
        logic [CHAR_W-1:0] char_in;
    } cell_ctl_t;

endpackage

>>> hw/rtl/leb_cell.sv
// ----------------------------------------------------------------------------
// leb_cell
// one character slot of the line; loads a put byte or its right neighbor
// ----------------------------------------------------------------------------
module leb_cell #(
    parameter int IDX = 0
) (
    input  logic                          clk,
    input  leb_pkg::cell_ctl_t            ctl,
    input  logic [leb_pkg::CHAR_W-1:0]    right_char,
    input  logic [leb_pkg::IDX_W-1:0]     read_index,
    output logic [leb_pkg::CHAR_W-1:0]    char_q,
    output logic [leb_pkg::CHAR_W-1:0]    rd_out
);
    import leb_pkg::*;

    localparam logic [WIDE_W-1:0] MY_IDX    = WIDE_W'(IDX);
    localparam logic [WIDE_W-1:0] MY_IDX_P1 = WIDE_W'(IDX + 1);

    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic [WIDE_W-1:0] cursor_w;
    logic [WIDE_W-1:0] count_w;
    logic              put_hit;
    logic              shift_hit;

    assign cursor_w  = {2'b00, ctl.cursor};
    assign count_w   = {2'b00, ctl.count};
    assign put_hit   = ctl.put_en && (cursor_w == MY_IDX);
    // slots from the cursor up to the second-last character pull from the right
    assign shift_hit = ctl.del_en && (MY_IDX >= cursor_w) && (MY_IDX_P1 < count_w);

    always_comb
    begin
        char_next = char_reg;
        if (put_hit)
        begin
            char_next = ctl.char_in;
        end
        else if (shift_hit)
        begin
            char_next = right_char;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign char_q = char_reg;
    assign rd_out = ({3'b000, read_index} == MY_IDX) ? char_reg : '0;

endmodule

>>> hw/rtl/leb_ctrl.sv
// ----------------------------------------------------------------------------
// leb_ctrl
// count and cursor registers, command decode and the result register
// ----------------------------------------------------------------------------
module leb_ctrl #(
    parameter int DEPTH = leb_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [leb_pkg::CMD_W-1:0]     cmd,
    input  logic [leb_pkg::CHAR_W-1:0]    char_in,
    input  logic [leb_pkg::IDX_W-1:0]     read_index,
    input  logic [leb_pkg::POS_W-1:0]     line_capacity,
    input  logic [leb_pkg::POS_W-1:0]     max_move,
    input  logic [leb_pkg::CHAR_W-1:0]    rd_data,
    output leb_pkg::cell_ctl_t            ctl,
    output logic                          done,
    output logic                          ok,
    output logic [leb_pkg::POS_W-1:0]     moved_by,
    output logic [leb_pkg::CHAR_W-1:0]    read_char,
    output logic [leb_pkg::POS_W-1:0]     char_count,
    output logic [leb_pkg::POS_W-1:0]     cursor_pos
);
    import leb_pkg::*;

    localparam logic [WIDE_W-1:0] DEPTH_W = WIDE_W'(DEPTH);

    logic [POS_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]  cursor_reg, cursor_next;
    logic              done_reg;
    logic              ok_reg, ok_next;
    logic [POS_W-1:0]  moved_reg, moved_next;
    logic [CHAR_W-1:0] rchar_reg, rchar_next;

    logic [WIDE_W-1:0] cap_eff;
    logic              put_ok;
    logic [POS_W-1:0]  span;

    assign cap_eff = ({2'b00, line_capacity} > DEPTH_W) ? DEPTH_W : {2'b00, line_capacity};
    assign put_ok  = {2'b00, cursor_reg} < cap_eff;
    assign span    = count_reg - cursor_reg;

    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        ok_next     = 1'b1;
        moved_next  = '0;
        rchar_next  = '0;
        unique case (cmd)
            CMD_PUT:
            begin
                if (!put_ok)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    if (count_reg == cursor_reg)
                    begin
                        count_next = count_reg + 7'd1;
                    end
                    cursor_next = cursor_reg + 7'd1;
                end
            end
            CMD_LEFT:
            begin
                if (cursor_reg == '0)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    cursor_next = cursor_reg - 7'd1;
                end
            end
            CMD_RIGHT:
            begin
                if (cursor_reg >= count_reg)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    cursor_next = cursor_reg + 7'd1;
                end
            end
            CMD_MAXL:
            begin
                moved_next  = (cursor_reg > max_move) ? max_move : cursor_reg;
                cursor_next = cursor_reg - moved_next;
            end
            CMD_MAXR:
            begin
                moved_next  = (span > max_move) ? max_move : span;
                cursor_next = cursor_reg + moved_next;
            end
            CMD_DELETE:
            begin
                if (cursor_reg >= count_reg)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    count_next = count_reg - 7'd1;
                end
            end
            CMD_CLEAR:
            begin
                count_next  = '0;
                cursor_next = '0;
            end
            CMD_READ:
            begin
                if ({1'b0, read_index} < count_reg)
                begin
                    rchar_next = rd_data;
                end
            end
            default:
            begin
                ok_next = 1'b1;
            end
        endcase
    end

    // cell controls see the state before the command
    always_comb
    begin
        ctl.put_en  = go && (cmd == CMD_PUT) && put_ok;
        ctl.del_en  = go && (cmd == CMD_DELETE) && (cursor_reg < count_reg);
        ctl.cursor  = cursor_reg;
        ctl.count   = count_reg;
        ctl.char_in = char_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            cursor_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= go;
            if (go)
            begin
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            ok_reg    <= ok_next;
            moved_reg <= moved_next;
            rchar_reg <= rchar_next;
        end
    end

    assign done       = done_reg;
    assign ok         = ok_reg;
    assign moved_by   = moved_reg;
    assign read_char  = rchar_reg;
    assign char_count = count_reg;
    assign cursor_pos = cursor_reg;

endmodule

>>> hw/rtl/line_edit_buffer_core.sv
// ----------------------------------------------------------------------------
// line_edit_buffer_core
// terminal line-editing buffer: a row of character cells with count and cursor
// ----------------------------------------------------------------------------
//  channel   signals                                         direction
//  command   start, busy, cmd, char_in, read_index           in (busy out)
//  result    done, ok, moved_by, read_char, char_count,      out
//            cursor_pos
//  config    psel, penable, pwrite, paddr, pwdata,           in (prdata,
//            prdata, pready                                   pready out)
//
//  every command is taken at the edge where start is high,
//  and its item shows on the result ports with done high in the next cycle
//  busy stays low, so a new command may follow every cycle; the cell row
//  shifts on delete in the same cycle, all cells at once
//  the receiver cannot stall; each result is shown for exactly one cycle
//  reset clears count, cursor and the strobe; stored characters are not cleared
// ----------------------------------------------------------------------------
module line_edit_buffer_core #(
    parameter int DEPTH = leb_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [leb_pkg::CMD_W-1:0]     cmd,
    input  logic [leb_pkg::CHAR_W-1:0]    char_in,
    input  logic [leb_pkg::IDX_W-1:0]     read_index,
    // result channel
    output logic                          done,
    output logic                          ok,
    output logic [leb_pkg::POS_W-1:0]     moved_by,
    output logic [leb_pkg::CHAR_W-1:0]    read_char,
    output logic [leb_pkg::POS_W-1:0]     char_count,
    output logic [leb_pkg::POS_W-1:0]     cursor_pos,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [leb_pkg::ADDR_W-1:0]    paddr,
    input  logic [leb_pkg::DATA_W-1:0]    pwdata,
    output logic [leb_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import leb_pkg::*;

    logic [POS_W-1:0]  cap_reg;
    logic [POS_W-1:0]  move_reg;
    logic              cfg_wr;
    logic              go;
    cell_ctl_t         ctl;
    logic [CHAR_W-1:0] cell_char [DEPTH];
    logic [CHAR_W-1:0] cell_rd   [DEPTH];
    logic [CHAR_W-1:0] rd_data;

    // ------------------------------------------------------------------------
    // register port: capacity at 0x0, max move at 0x4; low address bits ignored
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAP_RST;
            move_reg <= MOVE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_CAP:  cap_reg  <= pwdata[POS_W-1:0];
                REG_MOVE: move_reg <= pwdata[POS_W-1:0];
                default:  cap_reg  <= cap_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CAP:  prdata = {{(DATA_W-POS_W){1'b0}}, cap_reg};
            REG_MOVE: prdata = {{(DATA_W-POS_W){1'b0}}, move_reg};
            default:  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // command side: a command is taken whenever start is high, never busy
    // ------------------------------------------------------------------------
    assign busy = 1'b0;
    assign go   = start && !busy;

    leb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (go),
        .cmd           (cmd),
        .char_in       (char_in),
        .read_index    (read_index),
        .line_capacity (cap_reg),
        .max_move      (move_reg),
        .rd_data       (rd_data),
        .ctl           (ctl),
        .done          (done),
        .ok            (ok),
        .moved_by      (moved_by),
        .read_char     (read_char),
        .char_count    (char_count),
        .cursor_pos    (cursor_pos)
    );

    // ------------------------------------------------------------------------
    // cell row: each cell hands its byte to its left neighbor for delete;
    // the last cell sees zero on its right
    // ------------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [CHAR_W-1:0] right_char;

        if (g == DEPTH - 1)
        begin : g_last
            assign right_char = '0;
        end
        else
        begin : g_mid
            assign right_char = cell_char[g+1];
        end

        leb_cell #(
            .IDX (g)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .right_char (right_char),
            .read_index (read_index),
            .char_q     (cell_char[g]),
            .rd_out     (cell_rd[g])
        );
    end

    // read: each cell drives its byte only when it matches the index
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_data = rd_data | cell_rd[i];
        end
    end

endmodule

>>> hw/rtl/leb_chk.sv
// ----------------------------------------------------------------------------
// leb_chk
// port-level checks on command timing and result consistency
// ----------------------------------------------------------------------------
module leb_chk (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [leb_pkg::CMD_W-1:0]     cmd,
    input  logic                          done,
    input  logic                          ok,
    input  logic [leb_pkg::POS_W-1:0]     moved_by,
    input  logic [leb_pkg::POS_W-1:0]     char_count,
    input  logic [leb_pkg::POS_W-1:0]     cursor_pos
);
    import leb_pkg::*;

    // one item out for each item in, in the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("command taken without a result next cycle");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without a command");

    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cursor_pos <= char_count))
        else $error("cursor past the end of the line");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == CMD_CLEAR)) |=>
            (ok && (char_count == '0) && (cursor_pos == '0) && (moved_by == '0)))
        else $error("clear left a nonempty line");

endmodule

bind line_edit_buffer_core leb_chk u_leb_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .ok         (ok),
    .moved_by   (moved_by),
    .char_count (char_count),
    .cursor_pos (cursor_pos)
);

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for line_edit_buffer_core: a scoreboard model of the
// character row, count and cursor predicts every item, a clocked driver feeds
// commands from a queue with random gaps, a clocked monitor compares each
// result strobe with the oldest prediction, and the register port is walked
// through several capacity and jump settings, each read back after writing
// ----------------------------------------------------------------------------
module tb;

    import leb_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 100000;

    // one command item as the driver shows it
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] char_in;
        logic [IDX_W-1:0]  read_index;
    } edit_item_t;

    // one result item as the block strobes it
    typedef struct packed {
        logic              ok;
        logic [POS_W-1:0]  moved_by;
        logic [CHAR_W-1:0] read_char;
        logic [POS_W-1:0]  char_count;
        logic [POS_W-1:0]  cursor_pos;
    } edit_result_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // every block input starts at a known value
    logic                start      = 1'b0;
    logic [CMD_W-1:0]    cmd        = CMD_READ;
    logic [CHAR_W-1:0]   char_in    = '0;
    logic [IDX_W-1:0]    read_index = '0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [ADDR_W-1:0]   paddr      = '0;
    logic [DATA_W-1:0]   pwdata     = '0;

    logic                busy;
    logic                done;
    logic                ok;
    logic [POS_W-1:0]    moved_by;
    logic [CHAR_W-1:0]   read_char;
    logic [POS_W-1:0]    char_count;
    logic [POS_W-1:0]    cursor_pos;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // scoreboard copy of the line and its registers
    logic [CHAR_W-1:0]   line_mem [DEPTH];
    int                  line_len  = 0;
    int                  cur_pos   = 0;
    int                  cap_reg   = int'(CAP_RST);
    int                  jump_reg  = int'(MOVE_RST);

    edit_item_t          pending_edits [$];    // items waiting for the driver
    edit_result_t        awaited_results [$];  // predictions, oldest first
    edit_item_t          shown_edit;           // item currently on the command ports
    logic                no_gaps   = 1'b0;     // phase without any idle cycles
    int                  mismatches = 0;
    int                  cycle_count = 0;

    line_edit_buffer_core #(
        .DEPTH      (DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .char_in    (char_in),
        .read_index (read_index),
        .done       (done),
        .ok         (ok),
        .moved_by   (moved_by),
        .read_char  (read_char),
        .char_count (char_count),
        .cursor_pos (cursor_pos),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 12 unit period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // first ten failures are printed, the rest only counted
    task automatic log_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", what);
    endtask

    // apply one command to the scoreboard line and return what the block must show
    function automatic edit_result_t apply_edit(input edit_item_t it);
        edit_result_t r;
        int           limit;
        int           span;
        int           i;
        r       = '0;
        r.ok    = 1'b1;
        // capacity beyond the row is the row itself
        limit   = (cap_reg > DEPTH) ? DEPTH : cap_reg;
        case (it.cmd)
            CMD_PUT:
            begin
                // refused once the cursor sits at or past the capacity, even if
                // the capacity was lowered under characters already stored
                if (cur_pos >= limit)
                    r.ok = 1'b0;
                else
                begin
                    line_mem[cur_pos] = it.char_in;
                    if (line_len == cur_pos)
                        line_len++;
                    cur_pos++;
                end
            end
            CMD_LEFT:
            begin
                if (cur_pos == 0)
                    r.ok = 1'b0;
                else
                    cur_pos--;
            end
            CMD_RIGHT:
            begin
                if (cur_pos >= line_len)
                    r.ok = 1'b0;
                else
                    cur_pos++;
            end
            CMD_MAXL:
            begin
                // always succeeds, even with nothing to move
                span       = (cur_pos > jump_reg) ? jump_reg : cur_pos;
                cur_pos   -= span;
                r.moved_by = POS_W'(span);
            end
            CMD_MAXR:
            begin
                span       = line_len - cur_pos;
                span       = (span > jump_reg) ? jump_reg : span;
                cur_pos   += span;
                r.moved_by = POS_W'(span);
            end
            CMD_DELETE:
            begin
                if (cur_pos >= line_len)
                    r.ok = 1'b0;
                else
                begin
                    for (i = cur_pos; i + 1 < line_len && i + 1 < DEPTH; i++)
                        line_mem[i] = line_mem[i + 1];
                    line_len--;
                end
            end
            CMD_CLEAR:
            begin
                line_len = 0;
                cur_pos  = 0;
            end
            default:
            begin
                // read at or past the count shows zero
                if (int'(it.read_index) < line_len)
                    r.read_char = line_mem[it.read_index];
            end
        endcase
        r.char_count = POS_W'(line_len);
        r.cursor_pos = POS_W'(cur_pos);
        return r;
    endfunction

    // driver: predicts each item at the edge that takes it, then shows the
    // next one or idles; start is assigned once per edge
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
                awaited_results.push_back(apply_edit(shown_edit));
            if (!start || !busy)
            begin
                if (pending_edits.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 26))
                begin
                    shown_edit = pending_edits.pop_front();
                    start      <= 1'b1;
                    cmd        <= shown_edit.cmd;
                    char_in    <= shown_edit.char_in;
                    read_index <= shown_edit.read_index;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: every strobe is one result, taken at the edge that ends its cycle
    always @(posedge clk)
    begin
        edit_result_t got;
        edit_result_t want;
        if (rst_n && done)
        begin
            got = '{ok, moved_by, read_char, char_count, cursor_pos};
            if (awaited_results.size() == 0)
                log_mismatch($sformatf("unexpected result ok=%0d moved=%0d char=%02h cnt=%0d cur=%0d",
                    got.ok, got.moved_by, got.read_char, got.char_count, got.cursor_pos));
            else
            begin
                want = awaited_results.pop_front();
                if (got !== want)
                    log_mismatch($sformatf(
                        "result mismatch: exp ok=%0d moved=%0d char=%02h cnt=%0d cur=%0d, got ok=%0d moved=%0d char=%02h cnt=%0d cur=%0d",
                        want.ok, want.moved_by, want.read_char, want.char_count, want.cursor_pos,
                        got.ok, got.moved_by, got.read_char, got.char_count, got.cursor_pos));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_edit(input logic [CMD_W-1:0] c, input int ch, input int idx);
        edit_item_t it;
        it.cmd        = c;
        it.char_in    = CHAR_W'(ch);
        it.read_index = IDX_W'(idx);
        pending_edits.push_back(it);
    endtask

    // wait until every item is taken and every result has come, then a short pause
    task automatic drain();
        @(negedge clk);
        while (pending_edits.size() > 0 || start || awaited_results.size() > 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    // register write with junk in the unused upper bits, then a read back
    task automatic write_reg(input logic sel, input int value);
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] seen;
        word = ($urandom & ~32'h7f) | (value & 32'h7f);
        // setup then access; the write lands at the access edge
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {sel, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (sel == REG_CAP)
            cap_reg = value & 32'h7f;
        else
            jump_reg = value & 32'h7f;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        // read data is valid during the access cycle
        @(negedge clk);
        seen = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen !== DATA_W'(value & 32'h7f))
            log_mismatch($sformatf("register %0d read back: exp %0h, got %0h",
                sel, value & 32'h7f, seen));
    endtask

    // one setting of the registers followed by a burst of random commands;
    // put_w and clear_w steer how full the line gets
    task automatic run_phase(input int cap, input int jump, input int n,
                             input int put_w, input int clear_w, input logic steady);
        logic [CMD_W-1:0] others [6];
        int               k;
        int               roll;
        logic [CMD_W-1:0] c;
        others = '{CMD_LEFT, CMD_RIGHT, CMD_MAXL, CMD_MAXR, CMD_DELETE, CMD_READ};
        write_reg(REG_CAP, cap);
        write_reg(REG_MOVE, jump);
        no_gaps = steady;
        for (k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < put_w)
                c = CMD_PUT;
            else if (roll < put_w + clear_w)
                c = CMD_CLEAR;
            else
                c = others[$urandom_range(0, 5)];
            // reads lean toward the start of the line where characters live
            push_edit(c, $urandom_range(0, 255),
                ($urandom_range(0, 1) == 1) ? $urandom_range(0, 15) : $urandom_range(0, 63));
        end
        drain();
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: boundaries on an empty line with reset settings
        push_edit(CMD_READ,   8'h11, 0);     // read of an empty line
        push_edit(CMD_LEFT,   8'h22, 5);     // left at position zero
        push_edit(CMD_RIGHT,  8'h33, 7);     // right at the count
        push_edit(CMD_DELETE, 8'h44, 9);     // delete at the count
        push_edit(CMD_MAXL,   8'h55, 1);     // jump of zero still succeeds
        push_edit(CMD_MAXR,   8'h66, 2);
        // fill, overwrite in the middle, read back
        push_edit(CMD_PUT,    8'h00, 0);
        push_edit(CMD_PUT,    8'hff, 63);
        push_edit(CMD_PUT,    8'ha5, 0);
        push_edit(CMD_PUT,    8'h5a, 0);
        push_edit(CMD_LEFT,   8'h00, 0);
        push_edit(CMD_LEFT,   8'h00, 0);
        push_edit(CMD_PUT,    8'h3c, 0);     // overwrite keeps the count
        push_edit(CMD_READ,   8'h00, 0);
        push_edit(CMD_READ,   8'h00, 2);
        push_edit(CMD_READ,   8'hff, 63);    // far past the count
        push_edit(CMD_MAXL,   8'h00, 0);
        push_edit(CMD_RIGHT,  8'h00, 0);
        push_edit(CMD_DELETE, 8'h00, 0);     // shift the tail down
        push_edit(CMD_READ,   8'h00, 1);
        push_edit(CMD_READ,   8'h00, 3);     // index equal to the count
        push_edit(CMD_MAXR,   8'h00, 0);
        push_edit(CMD_CLEAR,  8'h00, 0);
        push_edit(CMD_READ,   8'h00, 0);
        drain();

        // random phases; state carries over so capacity can drop under the cursor
        run_phase(64,  64,  250, 55, 1, 1'b0);   // full line, put refused at the end
        run_phase(5,   0,   120, 40, 3, 1'b0);   // capacity below the cursor, no jumps
        run_phase(0,   127,  60, 40, 4, 1'b0);   // zero capacity, widest jump
        run_phase(127, 1,   250, 55, 1, 1'b0);   // capacity beyond the row
        run_phase(12,  5,   200, 45, 4, 1'b1);   // back to back items
        run_phase(1,   64,   80, 45, 4, 1'b0);
        run_phase(33,  7,   190, 50, 2, 1'b0);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/leb_pkg.sv
hw/rtl/leb_cell.sv
hw/rtl/leb_ctrl.sv
hw/rtl/line_edit_buffer_core.sv
hw/rtl/leb_chk.sv
verif/tb.sv
